>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the core RTL
// Clocked property checks with an active-low asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset
`define PDU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("core assertion failed");

// Check that a condition never holds outside reset
`define PDU_NEVER(lbl, clk, rstn, cond) \
  `PDU_ASSERT(lbl, clk, rstn, !(cond))

`endif

>>> rtl/core/pdu_pkg.sv
// ---------------------------------------------------------------------------
// pdu_pkg
// Types, constants and helpers of the packed nucleotide unpacker.
// ---------------------------------------------------------------------------
package pdu_pkg;

  // Block table capacities
  localparam int unsigned MaxNBlocks    = 64;
  localparam int unsigned MaxMaskBlocks = 64;

  // Table address and fill-count widths
  localparam int unsigned NAddrW = (MaxNBlocks > 1) ? $clog2(MaxNBlocks) : 1;
  localparam int unsigned MAddrW = (MaxMaskBlocks > 1) ? $clog2(MaxMaskBlocks) : 1;
  localparam int unsigned NCntW  = $clog2(MaxNBlocks + 1);
  localparam int unsigned MCntW  = $clog2(MaxMaskBlocks + 1);

  // Configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_REGION_START = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REGION_END   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SOFT_MASK    = 2'd2;

  // Character constants
  localparam logic [6:0] CharN      = 7'h4E;
  localparam logic [6:0] CaseOffset = 7'd32;

  // Request commands
  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ADD_N    = 2'd1,
    CMD_ADD_MASK = 2'd2,
    CMD_BYTE     = 2'd3
  } cmd_e;

  // One stored block: first position and one past the last
  typedef struct packed {
    logic [31:0] bstart;
    logic [32:0] bend;
  } blk_t;

  // Shared block compare unit: request and response
  typedef struct packed {
    logic [31:0] bstart;
    logic [32:0] bend;
    logic [32:0] pos;
  } cmp_req_t;

  typedef struct packed {
    logic passed;  // block ends at or before the position
    logic hit;     // block starts at or before the position
  } cmp_rsp_t;

  // Map a 2-bit base code to its upper-case letter
  function automatic logic [6:0] base_letter(input logic [1:0] code);
    logic [6:0] ch;
    unique case (code)
      2'd0:    ch = 7'h54;  // T
      2'd1:    ch = 7'h43;  // C
      2'd2:    ch = 7'h41;  // A
      default: ch = 7'h47;  // G
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/pdu_cover_cmp.sv
// ---------------------------------------------------------------------------
// pdu_cover_cmp
// Shared block compare unit: tests one stored block against a position.
// ---------------------------------------------------------------------------
module pdu_cover_cmp (
  input  pdu_pkg::cmp_req_t req_i,
  output pdu_pkg::cmp_rsp_t rsp_o
);

  // Block lies wholly behind the position: advance the cursor
  assign rsp_o.passed = (req_i.bend <= req_i.pos);

  // Block has begun at the position
  assign rsp_o.hit = ({1'b0, req_i.bstart} <= req_i.pos);

endmodule

>>> rtl/core/packed_dna_unpack_with_masking.sv
// ---------------------------------------------------------------------------
// packed_dna_unpack_with_masking
// Unpacks 2-bit packed bases to ASCII with N blocks and soft masking.
// ---------------------------------------------------------------------------
// Each packed byte request yields up to four bases, one result per base, for
// the region [region_start, region_end). Block requests (add N, add mask,
// clear) are done in the idle state. A byte request works one base at a
// time: the N table lookup reads the table and then compares, per cursor
// step, and is skipped once the cursor has run past the loaded blocks; the
// mask lookup, when soft masking is on and the base is not N, works the same
// way; the base then goes to the result register, waiting while the receiver
// still holds the last result. Every block the cursor passes costs one more
// read and compare. The pace is set by the single read port of each block
// table and the one compare unit that serves both tables. No new request is
// taken during a byte; the next request may be taken while the last result
// still waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module packed_dna_unpack_with_masking (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pdu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic [31:0]                  block_start_i,
  input  logic [31:0]                  block_size_i,
  input  logic [7:0]                   packed_byte_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [6:0]                   base_char_o,
  output logic [31:0]                  base_position_o,
  output logic                         last_base_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_N_RD,
    ST_N_TST,
    ST_M_RD,
    ST_M_TST,
    ST_LOAD
  } state_e;

  // Sequencer and control state
  state_e                      state_q, state_d;
  logic [31:0]                 region_start_q, region_start_d;
  logic [31:0]                 region_end_q, region_end_d;
  logic                        soft_en_q, soft_en_d;
  logic [pdu_pkg::NCntW-1:0]   n_count_q, n_count_d;
  logic [pdu_pkg::MCntW-1:0]   m_count_q, m_count_d;
  logic [pdu_pkg::NCntW-1:0]   n_cursor_q, n_cursor_d;
  logic [pdu_pkg::MCntW-1:0]   m_cursor_q, m_cursor_d;
  logic [32:0]                 np_q, np_d;
  logic [1:0]                  off_q, off_d;
  logic [7:0]                  byte_q, byte_d;
  logic [6:0]                  ch_q, ch_d;
  logic                        out_valid_q, out_valid_d;
  logic [6:0]                  out_char_q, out_char_d;
  logic [31:0]                 out_pos_q, out_pos_d;
  logic                        out_last_q, out_last_d;

  // Block tables
  pdu_pkg::blk_t n_mem [pdu_pkg::MaxNBlocks];
  pdu_pkg::blk_t m_mem [pdu_pkg::MaxMaskBlocks];
  pdu_pkg::blk_t n_rd_q, m_rd_q;
  pdu_pkg::blk_t new_blk;
  logic          n_we, m_we;

  // Shared compare unit
  pdu_pkg::cmp_req_t cmp_req;
  pdu_pkg::cmp_rsp_t cmp_rsp;

  logic        in_acc;
  logic [32:0] region_end_x;
  logic [1:0]  code;
  logic [6:0]  letter;
  logic [32:0] np_inc;
  logic [32:0] np_round;
  logic        slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  assign out_valid_o     = out_valid_q;
  assign base_char_o     = out_char_q;
  assign base_position_o = out_pos_q;
  assign last_base_o     = out_last_q;

  assign region_end_x = {1'b0, region_end_q};

  // Block entry built from the request
  assign new_blk.bstart = block_start_i;
  assign new_blk.bend   = {1'b0, block_start_i} + {1'b0, block_size_i};

  // Pick the current base out of the byte, first base in the top pair
  always_comb begin
    unique case (off_q)
      2'd0:    code = byte_q[7:6];
      2'd1:    code = byte_q[5:4];
      2'd2:    code = byte_q[3:2];
      default: code = byte_q[1:0];
    endcase
  end
  assign letter = pdu_pkg::base_letter(code);

  // Position arithmetic for the load step
  assign np_inc    = np_q + 33'd1;
  assign np_round  = {np_inc[32:2] + {30'd0, |np_inc[1:0]}, 2'b00};
  assign slot_free = !out_valid_q || out_ready_i;

  // Feed the compare unit from whichever table is under test
  always_comb begin
    if (state_q == ST_M_TST) begin
      cmp_req.bstart = m_rd_q.bstart;
      cmp_req.bend   = m_rd_q.bend;
    end else begin
      cmp_req.bstart = n_rd_q.bstart;
      cmp_req.bend   = n_rd_q.bend;
    end
    cmp_req.pos = np_q;
  end

  pdu_cover_cmp u_cmp (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  // Next-state logic of the sequencer
  always_comb begin
    state_d        = state_q;
    region_start_d = region_start_q;
    region_end_d   = region_end_q;
    soft_en_d      = soft_en_q;
    n_count_d      = n_count_q;
    m_count_d      = m_count_q;
    n_cursor_d     = n_cursor_q;
    m_cursor_d     = m_cursor_q;
    np_d           = np_q;
    off_d          = off_q;
    byte_d         = byte_q;
    ch_d           = ch_q;
    out_valid_d    = out_valid_q;
    out_char_d     = out_char_q;
    out_pos_d      = out_pos_q;
    out_last_d     = out_last_q;
    n_we           = 1'b0;
    m_we           = 1'b0;

    // Drop a result once it has been taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        // Handle a request
        if (in_acc) begin
          unique case (pdu_pkg::cmd_e'(cmd_i))
            pdu_pkg::CMD_CLEAR: begin
              n_count_d  = '0;
              m_count_d  = '0;
              n_cursor_d = '0;
              m_cursor_d = '0;
              np_d       = {1'b0, region_start_q};
            end
            pdu_pkg::CMD_ADD_N: begin
              if (n_count_q < pdu_pkg::NCntW'(pdu_pkg::MaxNBlocks)) begin
                n_we      = 1'b1;
                n_count_d = pdu_pkg::NCntW'(n_count_q + 1'b1);
              end
            end
            pdu_pkg::CMD_ADD_MASK: begin
              if (m_count_q < pdu_pkg::MCntW'(pdu_pkg::MaxMaskBlocks)) begin
                m_we      = 1'b1;
                m_count_d = pdu_pkg::MCntW'(m_count_q + 1'b1);
              end
            end
            pdu_pkg::CMD_BYTE: begin
              if (np_q < region_end_x) begin
                byte_d  = packed_byte_i;
                off_d   = np_q[1:0];
                state_d = ST_N_RD;
              end
            end
            default: ;
          endcase
        end
        // Handle a configuration write
        if (cfg_valid_i) begin
          unique case (cfg_index_i)
            pdu_pkg::CFG_REGION_START: begin
              region_start_d = cfg_data_i;
              np_d           = {1'b0, cfg_data_i};
              n_cursor_d     = '0;
              m_cursor_d     = '0;
            end
            pdu_pkg::CFG_REGION_END: region_end_d = cfg_data_i;
            pdu_pkg::CFG_SOFT_MASK:  soft_en_d    = cfg_data_i[0];
            default: ;
          endcase
        end
      end

      ST_N_RD: begin
        // Skip the N lookup once the cursor has run past the table
        if (n_cursor_q >= n_count_q) begin
          if (soft_en_q) begin
            state_d = ST_M_RD;
          end else begin
            ch_d    = letter;
            state_d = ST_LOAD;
          end
        end else begin
          state_d = ST_N_TST;
        end
      end

      ST_N_TST: begin
        if (cmp_rsp.passed) begin
          n_cursor_d = pdu_pkg::NCntW'(n_cursor_q + 1'b1);
          state_d    = ST_N_RD;
        end else if (cmp_rsp.hit) begin
          ch_d    = pdu_pkg::CharN;
          state_d = ST_LOAD;
        end else if (soft_en_q) begin
          state_d = ST_M_RD;
        end else begin
          ch_d    = letter;
          state_d = ST_LOAD;
        end
      end

      ST_M_RD: begin
        if (m_cursor_q >= m_count_q) begin
          ch_d    = letter;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_M_TST;
        end
      end

      ST_M_TST: begin
        if (cmp_rsp.passed) begin
          m_cursor_d = pdu_pkg::MCntW'(m_cursor_q + 1'b1);
          state_d    = ST_M_RD;
        end else if (cmp_rsp.hit) begin
          ch_d    = letter + pdu_pkg::CaseOffset;
          state_d = ST_LOAD;
        end else begin
          ch_d    = letter;
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        // Hand the base to the result register and advance
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ch_q;
          out_pos_d   = np_q[31:0];
          out_last_d  = (np_inc == region_end_x);
          if ((off_q == 2'd3) || !(np_inc < region_end_x)) begin
            np_d    = np_round;
            state_d = ST_IDLE;
          end else begin
            np_d    = np_inc;
            off_d   = off_q + 2'd1;
            state_d = ST_N_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      region_start_q <= '0;
      region_end_q   <= '0;
      soft_en_q      <= 1'b0;
      n_count_q      <= '0;
      m_count_q      <= '0;
      n_cursor_q     <= '0;
      m_cursor_q     <= '0;
      np_q           <= '0;
      off_q          <= '0;
      byte_q         <= '0;
      ch_q           <= '0;
      out_valid_q    <= 1'b0;
      out_char_q     <= '0;
      out_pos_q      <= '0;
      out_last_q     <= 1'b0;
    end else begin
      state_q        <= state_d;
      region_start_q <= region_start_d;
      region_end_q   <= region_end_d;
      soft_en_q      <= soft_en_d;
      n_count_q      <= n_count_d;
      m_count_q      <= m_count_d;
      n_cursor_q     <= n_cursor_d;
      m_cursor_q     <= m_cursor_d;
      np_q           <= np_d;
      off_q          <= off_d;
      byte_q         <= byte_d;
      ch_q           <= ch_d;
      out_valid_q    <= out_valid_d;
      out_char_q     <= out_char_d;
      out_pos_q      <= out_pos_d;
      out_last_q     <= out_last_d;
    end
  end

  // N table: append at the fill count, read at the cursor
  always_ff @(posedge clk_i) begin
    if (n_we) begin
      n_mem[n_count_q[pdu_pkg::NAddrW-1:0]] <= new_blk;
    end
    n_rd_q <= n_mem[n_cursor_q[pdu_pkg::NAddrW-1:0]];
  end

  // Mask table: append at the fill count, read at the cursor
  always_ff @(posedge clk_i) begin
    if (m_we) begin
      m_mem[m_count_q[pdu_pkg::MAddrW-1:0]] <= new_blk;
    end
    m_rd_q <= m_mem[m_cursor_q[pdu_pkg::MAddrW-1:0]];
  end

  // Fill counts stay within capacity
  `PDU_ASSERT(a_n_count_cap, clk_i, rst_ni, n_count_q <= pdu_pkg::NCntW'(pdu_pkg::MaxNBlocks))
  `PDU_ASSERT(a_m_count_cap, clk_i, rst_ni, m_count_q <= pdu_pkg::MCntW'(pdu_pkg::MaxMaskBlocks))
  // Cursors never run past the loaded blocks
  `PDU_ASSERT(a_n_cursor_in, clk_i, rst_ni, n_cursor_q <= n_count_q)
  `PDU_ASSERT(a_m_cursor_in, clk_i, rst_ni, m_cursor_q <= m_count_q)
  // A base under work lies inside the region
  `PDU_ASSERT(a_busy_in_region, clk_i, rst_ni, (state_q != ST_IDLE) |-> (np_q < region_end_x))

endmodule
